// ----- rtl/tcrt_pkg.sv -----
// Shared constants, command/status types and helpers for the reload down-timer.
// Used by tcrt_ctrl, tcrt_datapath and the top level; depends on nothing.
package tcrt_pkg;

  localparam int CHANNELS  = 3;
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int KIND_W    = 2;
  localparam int IDX_W     = 4;
  localparam int DATA_W    = 32;
  localparam int CYC_W     = 10;
  localparam int IRQ_W     = 3;
  localparam int IRQ_ACC_W = (CHANNELS > IRQ_W) ? CHANNELS : IRQ_W;
  localparam int REM_W     = 13;
  localparam int CTL_W     = 16;
  localparam int START_W   = 8;
  localparam int PSC_W     = 3;

  localparam int S_TDATA_W = 48;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 40;

  // request kinds
  localparam logic [KIND_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] REQ_READ  = 2'd1;
  localparam logic [KIND_W-1:0] REQ_WRITE = 2'd2;

  // register map
  localparam int REG_START        = 0;
  localparam int REG_RELOAD_BASE  = 1;
  localparam int REG_COUNTER_BASE = 1 + CHANNELS;
  localparam int REG_CONTROL_BASE = 1 + 2 * CHANNELS;

  // control word bits
  localparam int CTL_UNIE_BIT = 5;
  localparam int CTL_UNF_BIT  = 8;

  // prescaler divisor per code; the unused codes fall back to 16
  localparam logic [REM_W-1:0] PSC_DIV [8] = '{
    REM_W'(16), REM_W'(64), REM_W'(256), REM_W'(1024),
    REM_W'(4096), REM_W'(16), REM_W'(16), REM_W'(16)
  };

  typedef struct packed {
    logic tick_start;
    logic add;
    logic step;
    logic next_ch;
    logic reg_done;
    logic rd;
    logic wr;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic need_step;
    logic last_ch;
  } stat_t;

  function automatic logic idx_is(logic [IDX_W-1:0] idx, int n);
    return int'(idx) == n;
  endfunction

endpackage

// ----- rtl/tcrt_ctrl.sv -----
// Sequencer for the reload down-timer: accepts requests, walks the channels
// count by count on a tick and hands results to the output register.
// Depends on tcrt_pkg.
module tcrt_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [tcrt_pkg::KIND_W-1:0]   req_type,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  input  tcrt_pkg::stat_t               stat,
  output tcrt_pkg::cmd_t                cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ADD  = 4'b0010,
    S_STEP = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          unique case (req_type)
            tcrt_pkg::REQ_TICK: begin
              cmd.tick_start = 1'b1;
              state_next     = S_ADD;
            end
            tcrt_pkg::REQ_READ: begin
              cmd.reg_done = 1'b1;
              cmd.rd       = 1'b1;
              state_next   = S_DONE;
            end
            tcrt_pkg::REQ_WRITE: begin
              cmd.reg_done = 1'b1;
              cmd.wr       = 1'b1;
              state_next   = S_DONE;
            end
            default: begin
              cmd.reg_done = 1'b1;
              state_next   = S_DONE;
            end
          endcase
        end
      end
      S_ADD: begin
        cmd.add    = 1'b1;
        state_next = S_STEP;
      end
      S_STEP: begin
        // one count per cycle until the remainder drops below the divisor
        if (stat.need_step) begin
          cmd.step = 1'b1;
        end else if (stat.last_ch) begin
          state_next = S_DONE;
        end else begin
          cmd.next_ch = 1'b1;
          state_next  = S_ADD;
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!m_tvalid || m_tready))
    else $error("output register overwritten while a result waits");

  a_no_load_on_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> !cmd.load_out)
    else $error("result loaded in the cycle a request is accepted");

  a_step_needed: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (stat.need_step && !cmd.next_ch))
    else $error("count taken without a whole divisor in the remainder");

  a_channel_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.next_ch |-> !stat.last_ch)
    else $error("channel index advanced past the last channel");

endmodule

// ----- rtl/tcrt_datapath.sv -----
// Register file, per-channel counting lanes and result/output registers of
// the reload down-timer. Driven by commands from tcrt_ctrl; depends on tcrt_pkg.
module tcrt_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  tcrt_pkg::cmd_t                cmd,
  output tcrt_pkg::stat_t               stat,
  input  logic [tcrt_pkg::IDX_W-1:0]    req_index,
  input  logic [tcrt_pkg::DATA_W-1:0]   write_data,
  input  logic [tcrt_pkg::CYC_W-1:0]    elapsed_cycles,
  output logic [tcrt_pkg::DATA_W-1:0]   read_data,
  output logic [tcrt_pkg::IRQ_W-1:0]    irq_pending
);

  localparam int C = tcrt_pkg::CHANNELS;

  logic [tcrt_pkg::START_W-1:0]   start_bits;
  logic [tcrt_pkg::START_W-1:0]   prev_start_bits;
  logic [tcrt_pkg::REM_W-1:0]     cycle_remainder [C];
  logic [tcrt_pkg::DATA_W-1:0]    down_counter    [C];
  logic [tcrt_pkg::DATA_W-1:0]    reload_value    [C];
  logic [tcrt_pkg::CTL_W-1:0]     control_word    [C];

  logic [C-1:0]                   fresh;
  logic [tcrt_pkg::CH_W-1:0]      ch;
  logic [tcrt_pkg::REM_W-1:0]     cycles;
  logic [tcrt_pkg::DATA_W-1:0]    res_rd;
  logic [tcrt_pkg::IRQ_ACC_W-1:0] irq_acc;

  logic [C-1:0]                   ch_hit;
  logic [C-1:0]                   lane_due;
  logic [C-1:0]                   lane_irq;
  logic [tcrt_pkg::REM_W-1:0]     lane_div [C];
  logic [tcrt_pkg::DATA_W-1:0]    rd_val;

  always_comb begin
    for (int i = 0; i < C; i++) begin
      ch_hit[i]   = (ch == tcrt_pkg::CH_W'(i));
      lane_div[i] = tcrt_pkg::PSC_DIV[control_word[i][tcrt_pkg::PSC_W-1:0]];
      lane_due[i] = ch_hit[i] && start_bits[i] && (cycle_remainder[i] >= lane_div[i]);
      lane_irq[i] = ch_hit[i] && cmd.step && (down_counter[i] == '0)
                    && control_word[i][tcrt_pkg::CTL_UNIE_BIT];
    end
  end

  assign stat.need_step = |lane_due;
  assign stat.last_ch   = (ch == tcrt_pkg::CH_W'(C - 1));

  always_comb begin
    rd_val = '0;
    if (tcrt_pkg::idx_is(req_index, tcrt_pkg::REG_START)) begin
      rd_val = tcrt_pkg::DATA_W'(start_bits);
    end
    for (int i = 0; i < C; i++) begin
      if (tcrt_pkg::idx_is(req_index, tcrt_pkg::REG_RELOAD_BASE + i)) begin
        rd_val = reload_value[i];
      end
      if (tcrt_pkg::idx_is(req_index, tcrt_pkg::REG_COUNTER_BASE + i)) begin
        rd_val = down_counter[i];
      end
      if (tcrt_pkg::idx_is(req_index, tcrt_pkg::REG_CONTROL_BASE + i)) begin
        rd_val = tcrt_pkg::DATA_W'(control_word[i]);
      end
    end
  end

  // architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_bits      <= '0;
      prev_start_bits <= '0;
      for (int i = 0; i < C; i++) begin
        cycle_remainder[i] <= '0;
        down_counter[i]    <= '1;
        reload_value[i]    <= '1;
        control_word[i]    <= '0;
      end
    end else begin
      if (cmd.tick_start) begin
        prev_start_bits <= start_bits;
      end
      if (cmd.wr && tcrt_pkg::idx_is(req_index, tcrt_pkg::REG_START)) begin
        start_bits <= write_data[tcrt_pkg::START_W-1:0];
      end
      for (int i = 0; i < C; i++) begin
        if (cmd.add && ch_hit[i] && start_bits[i]) begin
          // a channel that just started drops its old remainder
          cycle_remainder[i] <= (fresh[i] ? '0 : cycle_remainder[i]) + cycles;
        end
        if (cmd.step && ch_hit[i]) begin
          cycle_remainder[i] <= cycle_remainder[i] - lane_div[i];
          if (down_counter[i] == '0) begin
            down_counter[i]                        <= reload_value[i];
            control_word[i][tcrt_pkg::CTL_UNF_BIT] <= 1'b1;
          end else begin
            down_counter[i] <= down_counter[i] - 1'b1;
          end
        end
        if (cmd.wr) begin
          if (tcrt_pkg::idx_is(req_index, tcrt_pkg::REG_RELOAD_BASE + i)) begin
            reload_value[i] <= write_data;
          end
          if (tcrt_pkg::idx_is(req_index, tcrt_pkg::REG_COUNTER_BASE + i)) begin
            down_counter[i] <= write_data;
          end
          if (tcrt_pkg::idx_is(req_index, tcrt_pkg::REG_CONTROL_BASE + i)) begin
            control_word[i] <= write_data[tcrt_pkg::CTL_W-1:0];
          end
        end
      end
    end
  end

  // channel walk index
  always_ff @(posedge clk) begin
    if (rst) begin
      ch <= '0;
    end else if (cmd.tick_start) begin
      ch <= '0;
    end else if (cmd.next_ch) begin
      ch <= ch + 1'b1;
    end
  end

  // per-transaction working and result registers
  always_ff @(posedge clk) begin
    if (cmd.tick_start) begin
      cycles  <= tcrt_pkg::REM_W'(elapsed_cycles);
      fresh   <= start_bits[C-1:0] & ~prev_start_bits[C-1:0];
      res_rd  <= '0;
      irq_acc <= '0;
    end else if (cmd.reg_done) begin
      res_rd  <= cmd.rd ? rd_val : '0;
      irq_acc <= '0;
    end else begin
      irq_acc <= irq_acc | tcrt_pkg::IRQ_ACC_W'(lane_irq);
    end
    if (cmd.load_out) begin
      read_data   <= res_rd;
      irq_pending <= irq_acc[tcrt_pkg::IRQ_W-1:0];
    end
  end

endmodule

// ----- rtl/three_channel_reload_down_timer_top.sv -----
// Three-channel prescaled reload down-timer behind a small register file,
// fronted by stream channels. One request is in work at a time. A read, a
// write or an unknown request goes from acceptance to S_DONE and is loaded
// into the output register once that is free. A tick walks the channels in
// turn through S_ADD and S_STEP, then S_DONE; each started channel gives
// floor((remainder + elapsed_cycles) / divisor) counts, and the counting lane
// of the channel being walked takes one count per cycle. At the divide-by-16
// prescaler an elapsed_cycles of up to 1023 gives at most 64 counts a channel,
// more if the prescaler was lowered while a large remainder was held. A new
// request is taken while the previous result still waits in the output
// register. Depends on tcrt_pkg, tcrt_ctrl and tcrt_datapath.
module three_channel_reload_down_timer_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // reg_index [3:0], write_data [35:4], elapsed_cycles [45:36], zero pad [47:46]
  input  logic [tcrt_pkg::S_TDATA_W-1:0]   s_tdata,
  // req_type [1:0]
  input  logic [tcrt_pkg::S_TUSER_W-1:0]   s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // read_data [31:0], irq_pending [34:32], zero pad [39:35]
  output logic [tcrt_pkg::M_TDATA_W-1:0]   m_tdata
);

  localparam int M_PAD_W = tcrt_pkg::M_TDATA_W - tcrt_pkg::DATA_W - tcrt_pkg::IRQ_W;

  tcrt_pkg::cmd_t                cmd;
  tcrt_pkg::stat_t               stat;
  logic [tcrt_pkg::DATA_W-1:0]   read_data;
  logic [tcrt_pkg::IRQ_W-1:0]    irq_pending;

  tcrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .req_type (s_tuser[tcrt_pkg::KIND_W-1:0]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcrt_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .req_index      (s_tdata[3:0]),
    .write_data     (s_tdata[35:4]),
    .elapsed_cycles (s_tdata[45:36]),
    .read_data      (read_data),
    .irq_pending    (irq_pending)
  );

  assign m_tdata = {M_PAD_W'(0), irq_pending, read_data};

endmodule

// ----- tb/tcrt_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the three-channel reload down-timer: watches both stream channels,
// keeps its own copy of the timer state to predict each response, and compares.
// Depends on tcrt_pkg.
module tcrt_checker
  import tcrt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  // reg_index [3:0], write_data [35:4], elapsed_cycles [45:36], zero pad [47:46]
  input  logic [S_TDATA_W-1:0] s_tdata,
  // req_type [1:0]
  input  logic [S_TUSER_W-1:0] s_tuser,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  // read_data [31:0], irq_pending [34:32], zero pad [39:35]
  input  logic [M_TDATA_W-1:0] m_tdata,
  output int                   fail_count,
  output int                   responses_owed
);

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [IRQ_W-1:0]  irq_pending;
  } timer_resp_t;

  logic [START_W-1:0] start_bits;
  logic [START_W-1:0] started_last_tick;
  logic [REM_W-1:0]   cycle_rem   [CHANNELS];
  logic [DATA_W-1:0]  counter_val [CHANNELS];
  logic [DATA_W-1:0]  reload_val  [CHANNELS];
  logic [CTL_W-1:0]   ctl_word    [CHANNELS];

  timer_resp_t resp_q[$];
  int          mismatches = 0;
  int          resp_seen  = 0;

  assign fail_count = mismatches;

  task automatic report_mismatch(string what, logic [DATA_W-1:0] want,
                                 logic [DATA_W-1:0] got);
    $display("%0t: response %0d: %s expected %h got %h", $time, resp_seen, what, want, got);
    mismatches++;
  endtask

  function automatic void clear_timers();
    start_bits        = '0;
    started_last_tick = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      cycle_rem[ch]   = '0;
      counter_val[ch] = '1;
      reload_val[ch]  = '1;
      ctl_word[ch]    = '0;
    end
  endfunction

  function automatic int unsigned prescale_div(logic [CTL_W-1:0] ctl);
    logic [PSC_W-1:0] code;
    code = ctl[PSC_W-1:0];
    return (code <= 3'd4) ? (32'd16 << (2 * code)) : 32'd16;
  endfunction

  // one tick: returns the channels that underflowed with interrupts enabled
  function automatic logic [IRQ_W-1:0] run_counters(logic [CYC_W-1:0] cycles);
    logic [START_W-1:0]   fresh;
    logic [IRQ_ACC_W-1:0] hit;
    int unsigned          div;
    fresh             = start_bits & ~started_last_tick;
    started_last_tick = start_bits;
    hit               = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      if (fresh[ch])
        cycle_rem[ch] = '0;
      if (start_bits[ch]) begin
        div           = prescale_div(ctl_word[ch]);
        cycle_rem[ch] = cycle_rem[ch] + cycles;
        while (cycle_rem[ch] >= div) begin
          cycle_rem[ch] = cycle_rem[ch] - REM_W'(div);
          if (counter_val[ch] == '0) begin
            counter_val[ch]           = reload_val[ch];
            ctl_word[ch][CTL_UNF_BIT] = 1'b1;
            if (ctl_word[ch][CTL_UNIE_BIT])
              hit[ch] = 1'b1;
          end else begin
            counter_val[ch] = counter_val[ch] - 1'b1;
          end
        end
      end
    end
    return hit[IRQ_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] read_reg(logic [IDX_W-1:0] idx);
    int i;
    i = int'(idx);
    if (i == REG_START)
      return DATA_W'(start_bits);
    if (i >= REG_RELOAD_BASE && i < REG_COUNTER_BASE)
      return reload_val[i - REG_RELOAD_BASE];
    if (i >= REG_COUNTER_BASE && i < REG_CONTROL_BASE)
      return counter_val[i - REG_COUNTER_BASE];
    if (i >= REG_CONTROL_BASE && i < REG_CONTROL_BASE + CHANNELS)
      return DATA_W'(ctl_word[i - REG_CONTROL_BASE]);
    return '0;
  endfunction

  function automatic void write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    int i;
    i = int'(idx);
    if (i == REG_START)
      start_bits = data[START_W-1:0];
    else if (i >= REG_RELOAD_BASE && i < REG_COUNTER_BASE)
      reload_val[i - REG_RELOAD_BASE] = data;
    else if (i >= REG_COUNTER_BASE && i < REG_CONTROL_BASE)
      counter_val[i - REG_COUNTER_BASE] = data;
    else if (i >= REG_CONTROL_BASE && i < REG_CONTROL_BASE + CHANNELS)
      ctl_word[i - REG_CONTROL_BASE] = data[CTL_W-1:0];
  endfunction

  function automatic timer_resp_t predict_response(logic [KIND_W-1:0] kind,
                                                   logic [IDX_W-1:0] idx,
                                                   logic [DATA_W-1:0] data,
                                                   logic [CYC_W-1:0] cycles);
    timer_resp_t r;
    r = '0;
    case (kind)
      REQ_TICK:  r.irq_pending = run_counters(cycles);
      REQ_READ:  r.read_data = read_reg(idx);
      REQ_WRITE: write_reg(idx, data);
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    timer_resp_t got;
    timer_resp_t want;
    if (rst) begin
      clear_timers();
      resp_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.read_data   = m_tdata[DATA_W-1:0];
        got.irq_pending = m_tdata[DATA_W +: IRQ_W];
        if (resp_q.size() == 0) begin
          report_mismatch("unexpected response, read_data", '0, got.read_data);
        end else begin
          want = resp_q.pop_front();
          if (got.read_data !== want.read_data)
            report_mismatch("read_data", want.read_data, got.read_data);
          if (got.irq_pending !== want.irq_pending)
            report_mismatch("irq_pending", DATA_W'(want.irq_pending),
                            DATA_W'(got.irq_pending));
        end
        resp_seen++;
      end
      if (s_tvalid && s_tready)
        resp_q.push_back(predict_response(s_tuser[KIND_W-1:0],
                                          s_tdata[IDX_W-1:0],
                                          s_tdata[IDX_W +: DATA_W],
                                          s_tdata[IDX_W + DATA_W +: CYC_W]));
    end
    responses_owed <= resp_q.size();
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the down-timer testbench: clock, reset, request stimulus and response
// back-pressure, plus the verdict. Depends on tcrt_pkg, tcrt_checker and the timer top.
module tb_top;
  import tcrt_pkg::*;

  localparam int TOTAL_ITEMS    = 1750;
  localparam int CALM_TAIL      = 250;
  localparam int BACKLOG_AT     = 300;
  localparam int BACKLOG_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 1100;

  // request kind the block must ignore
  localparam logic [KIND_W-1:0] REQ_NONE = 2'd3;

  localparam logic [CTL_W-1:0] PSC_DIV16   = 16'd0;
  localparam logic [CTL_W-1:0] PSC_DIV4096 = 16'd4;
  localparam logic [CTL_W-1:0] UNIE        = 16'(1 << CTL_UNIE_BIT);

  localparam logic [IDX_W-1:0] IDX_PAST_MAP = IDX_W'(REG_CONTROL_BASE + CHANNELS);
  localparam logic [IDX_W-1:0] IDX_TOP      = '1;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic [S_TUSER_W-1:0] s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;

  int fail_count;
  int responses_owed;
  int items_sent   = 0;
  bit backlog_done = 0;

  three_channel_reload_down_timer_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  tcrt_checker chk (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .fail_count     (fail_count),
    .responses_owed (responses_owed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("Some tests failed");
    $finish;
  end

  // offer one request and hold it until it is accepted
  task automatic send_req(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx,
                          logic [DATA_W-1:0] data, logic [CYC_W-1:0] cycles);
    s_tuser  <= kind;
    s_tdata  <= {{(S_TDATA_W - IDX_W - DATA_W - CYC_W){1'b0}}, cycles, data, idx};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    items_sent++;
    if (items_sent < TOTAL_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic send_random_item();
    int                pick;
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] data;
    logic [CYC_W-1:0]  cycles;
    pick   = $urandom_range(0, 99);
    idx    = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(0, 15))
                                         : IDX_W'($urandom_range(0, 3 * CHANNELS));
    data   = $urandom;
    cycles = CYC_W'($urandom_range(0, 1023));
    if (pick < 40) begin
      kind = REQ_TICK;
    end else if (pick < 65) begin
      kind = REQ_READ;
    end else if (pick < 96) begin
      kind = REQ_WRITE;
      // lean toward running channels and short counts so underflows happen often
      if (idx == REG_START) begin
        if ($urandom_range(0, 1) == 1)
          data[CHANNELS-1:0] = '1;
      end else if (idx >= REG_RELOAD_BASE && idx < REG_CONTROL_BASE) begin
        if ($urandom_range(0, 2) != 0)
          data = DATA_W'($urandom_range(0, 200));
      end else if (idx < REG_CONTROL_BASE + CHANNELS) begin
        if ($urandom_range(0, 1) == 1)
          data[CTL_UNIE_BIT] = 1'b1;
      end
    end else begin
      kind = REQ_NONE;
    end
    send_req(kind, idx, data, cycles);
  endtask

  // response side: random stalls, one long hold-off to back up the block
  initial begin
    m_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (!backlog_done && items_sent >= BACKLOG_AT) begin
        backlog_done = 1;
        m_tready <= 1'b0;
        repeat (BACKLOG_CYCLES) @(posedge clk);
      end else if (items_sent < TOTAL_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values, including an index past the register map
    send_req(REQ_READ, IDX_W'(REG_START), '0, '0);
    send_req(REQ_READ, IDX_W'(REG_RELOAD_BASE), '0, '0);
    send_req(REQ_READ, IDX_W'(REG_COUNTER_BASE + 2), '0, '0);
    send_req(REQ_READ, IDX_W'(REG_CONTROL_BASE + 2), '0, '0);
    send_req(REQ_READ, IDX_TOP, '1, '1);

    // channel 0 reloads from zero, channel 1 starts at zero with all control bits,
    // channel 2 on the slowest prescaler; spare start bits set too
    send_req(REQ_WRITE, IDX_W'(REG_RELOAD_BASE), '0, '0);
    send_req(REQ_WRITE, IDX_W'(REG_COUNTER_BASE), 32'd3, '0);
    send_req(REQ_WRITE, IDX_W'(REG_CONTROL_BASE), DATA_W'(UNIE | PSC_DIV16), '0);
    send_req(REQ_WRITE, IDX_W'(REG_CONTROL_BASE + 1), '1, '0);
    send_req(REQ_WRITE, IDX_W'(REG_CONTROL_BASE + 2), DATA_W'(UNIE | PSC_DIV4096), '0);
    send_req(REQ_WRITE, IDX_W'(REG_COUNTER_BASE + 1), '0, '0);
    send_req(REQ_WRITE, IDX_W'(REG_START), '1, '0);
    send_req(REQ_TICK, '1, '1, '1);
    send_req(REQ_TICK, '0, '0, '0);
    send_req(REQ_READ, IDX_W'(REG_CONTROL_BASE), '0, '0);
    send_req(REQ_READ, IDX_W'(REG_COUNTER_BASE + 1), '0, '0);

    // writes past the map are dropped; unknown kinds do nothing
    send_req(REQ_WRITE, IDX_PAST_MAP, '1, '0);
    send_req(REQ_READ, IDX_PAST_MAP, '0, '0);
    send_req(REQ_NONE, IDX_W'(REG_START), '1, '1);

    // stopped channels hold; restart clears the remainder
    send_req(REQ_WRITE, IDX_W'(REG_START), '0, '0);
    send_req(REQ_TICK, '0, '0, '1);
    send_req(REQ_WRITE, IDX_W'(REG_START), 32'h5, '0);
    send_req(REQ_TICK, '0, '0, '1);

    // drop channel 2 to the fastest prescaler while it holds a big remainder
    send_req(REQ_WRITE, IDX_W'(REG_CONTROL_BASE + 2), DATA_W'(UNIE | PSC_DIV16), '0);
    send_req(REQ_TICK, '0, '0, '1);
    send_req(REQ_READ, IDX_W'(REG_COUNTER_BASE + 2), '0, '0);

    while (items_sent < TOTAL_ITEMS)
      send_random_item();

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (responses_owed != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && responses_owed == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/tcrt_pkg.sv
rtl/tcrt_ctrl.sv
rtl/tcrt_datapath.sv
rtl/three_channel_reload_down_timer_top.sv
tb/tcrt_checker.sv
tb/tb_top.sv
